FILE: rtl/qap_pkg.sv
`default_nettype none
package qap_pkg;

    localparam int NumUsers   = 8;
    localparam int NumFrames  = 64;
    localparam int NumPages   = 256;
    localparam int UserW      = 3;
    localparam int PageW      = 8;
    localparam int FrameW     = 6;
    localparam int CountW     = 7;
    localparam int ScoreW     = 48;
    localparam int IdxW       = UserW + PageW;
    localparam int MapDepth   = NumUsers * NumPages;

    localparam logic [2:0] POL_STICKY = 3'd0;
    localparam logic [2:0] POL_LRU    = 3'd1;
    localparam logic [2:0] POL_MRU    = 3'd2;
    localparam logic [2:0] POL_LFU    = 3'd3;
    localparam logic [2:0] POL_LFRU   = 3'd4;
    localparam logic [2:0] POL_LFRUR  = 3'd5;
    localparam logic [2:0] POL_MFU    = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOVICT  = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;
    localparam logic [1:0] CFG_USERS  = 2'd2;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic                     sub;
        logic signed [ScoreW-1:0] a;
        logic signed [ScoreW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic signed [ScoreW-1:0] sum;
        logic                     lt;
        logic                     eq;
    } t_alu_rsp;

    typedef struct packed {
        logic [UserW-1:0]         user;
        logic [PageW-1:0]         page;
        logic signed [ScoreW-1:0] score;
    } t_frame_word;

endpackage
`default_nettype wire

FILE: rtl/qap_alu.sv
`default_nettype none
module qap_alu
    import qap_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    always_comb begin
        o_rsp.sum = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);
        o_rsp.lt  = i_req.a < i_req.b;
        o_rsp.eq  = i_req.a == i_req.b;
    end

endmodule
`default_nettype wire

FILE: rtl/quota_aware_page_replacement.sv
// A load finishes from idle; an access past the user's limit stops at the limit check. A hit
// or free-frame miss reads, scores and commits its frame; an evicting miss first scans the
// frame store, and one with no victim stops after the scan. Frame-store reads, one per frame
// through a single score comparator over 64 frames, set the eviction time. One request at a
// time; the next is taken in the o_done cycle. o_done strobes the result for one cycle; the
// receiver cannot stall it. Reset (i_rst_n low, synchronous) starts a sweep that clears all 2048
// page-map and frequency entries; busy stays high until it ends. Config writes are taken anytime.
`default_nettype none
module quota_aware_page_replacement
    import qap_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        i_opcode,
    input  wire [2:0]  i_user,
    input  wire [7:0]  i_page,
    input  wire [9:0]  i_priority_req,
    input  wire [6:0]  i_min_quota,
    input  wire [6:0]  i_max_quota,
    input  wire [8:0]  i_page_limit,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [6:0]  i_cfg_data,
    output logic       o_done,
    output logic [5:0] o_frame,
    output logic       o_hit,
    output logic       o_evicted,
    output logic [2:0] o_victim_user,
    output logic [7:0] o_victim_page,
    output logic [1:0] o_status
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_LOOK   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_TAIL   = 4'd5;
    localparam logic [3:0] S_FRD    = 4'd6;
    localparam logic [3:0] S_EVICT  = 4'd7;
    localparam logic [3:0] S_SC1    = 4'd8;
    localparam logic [3:0] S_SC2    = 4'd9;
    localparam logic [3:0] S_COMMIT = 4'd10;

    // Configuration registers
    logic [2:0] r_policy;
    logic [6:0] r_frames;
    logic [3:0] r_users;

    // Sequencer and request
    logic [3:0]        r_state;
    logic [IdxW:0]     r_clr;
    logic [UserW-1:0]  r_u;
    logic [PageW-1:0]  r_pg;
    logic [FrameW-1:0] r_q;
    logic              r_hit;
    logic [6:0]        r_fp;
    logic [31:0]       r_time;

    // Per-user settings and counts
    logic [CountW-1:0] r_cnt  [NumUsers];
    logic [9:0]        r_pri  [NumUsers];
    logic [CountW-1:0] r_min  [NumUsers];
    logic [CountW-1:0] r_max  [NumUsers];
    logic [8:0]        r_pgs  [NumUsers];
    logic [NumUsers-1:0]  r_elig;
    logic [NumFrames-1:0] r_occ;

    // Victim scan
    logic [FrameW:0]          r_k;
    logic [FrameW-1:0]        r_kp;
    logic                     r_pv;
    logic                     r_have;
    logic signed [ScoreW-1:0] r_best;
    logic [UserW-1:0]         r_bu;
    logic signed [ScoreW-1:0] r_acc;

    // Result registers
    logic       r_done;
    logic [5:0] r_o_frame;
    logic       r_o_hit;
    logic       r_o_evicted;
    logic [2:0] r_o_vu;
    logic [7:0] r_o_vp;
    logic [1:0] r_o_status;

    // Memories
    logic [6:0]  map_mem  [MapDepth];
    logic [31:0] freq_mem [MapDepth];
    t_frame_word fs_mem   [NumFrames];
    logic [6:0]  map_rd;
    logic [31:0] freq_rd;
    t_frame_word fs_rd;

    logic            map_we, freq_we, fs_we;
    logic [IdxW-1:0] map_wa, freq_wa;
    logic [6:0]      map_wd;
    logic [31:0]     freq_wd;
    logic [FrameW-1:0] fs_ra;
    t_frame_word     fs_wd;

    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  oidx;
    logic [6:0]       nf;
    logic [3:0]       nu;
    logic [8:0]       lim;
    logic [31:0]      f_new;
    logic [14:0]      prio32;
    logic             upd;
    logic             occ_q;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    qap_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign idx    = {r_u, r_pg};
    assign oidx   = {fs_rd.user, fs_rd.page};
    assign nf     = (r_frames > 7'(NumFrames)) ? 7'(NumFrames) : r_frames;
    assign nu     = (r_users > 4'(NumUsers)) ? 4'(NumUsers) : r_users;
    assign lim    = (r_pgs[r_u] > 9'(NumPages)) ? 9'(NumPages) : r_pgs[r_u];
    assign f_new  = freq_rd + 32'd1;
    assign prio32 = {r_pri[r_u], 5'd0};
    assign occ_q  = r_occ[r_q];
    assign busy   = (r_state != S_IDLE);

    assign o_done        = r_done;
    assign o_frame       = r_o_frame;
    assign o_hit         = r_o_hit;
    assign o_evicted     = r_o_evicted;
    assign o_victim_user = r_o_vu;
    assign o_victim_page = r_o_vp;
    assign o_status      = r_o_status;

    // Shared adder/comparator: scan compares in S_SCAN/S_TAIL, score build in S_SC1/S_SC2
    always_comb begin
        alu_req = '0;
        case (r_state)
            S_SCAN, S_TAIL: begin
                alu_req.a = fs_rd.score;
                alu_req.b = r_best;
            end
            S_SC1: begin
                case (r_policy)
                    POL_STICKY: alu_req.a = r_hit ? r_acc : ScoreW'(r_time);
                    POL_MRU: begin
                        alu_req.sub = 1'b1;
                        alu_req.b   = ScoreW'(r_time);
                    end
                    POL_LFU:  alu_req.a = ScoreW'(f_new);
                    POL_LFRU, POL_LFRUR: begin
                        alu_req.a = ScoreW'({f_new, 6'd0});
                        alu_req.b = ScoreW'(r_time);
                    end
                    POL_MFU: begin
                        alu_req.sub = 1'b1;
                        alu_req.b   = ScoreW'(f_new);
                    end
                    default: alu_req.a = ScoreW'(r_time);
                endcase
            end
            S_SC2: begin
                alu_req.a = r_acc;
                alu_req.b = (r_policy == POL_STICKY && r_hit) ? '0 : ScoreW'(prio32);
            end
            default: alu_req = '0;
        endcase
    end

    // Take the frame if it is eligible and beats the best so far
    assign upd = r_pv && r_occ[r_kp] && r_elig[fs_rd.user] &&
                 (!r_have || alu_rsp.lt || (alu_rsp.eq && fs_rd.user < r_bu));

    // Memory write steering
    always_comb begin
        map_we  = 1'b0;
        map_wa  = idx;
        map_wd  = '0;
        freq_we = 1'b0;
        freq_wa = idx;
        freq_wd = '0;
        fs_we   = 1'b0;
        fs_wd   = '{user: r_u, page: r_pg, score: r_acc};
        fs_ra   = (r_state == S_SCAN) ? r_k[FrameW-1:0] : r_q;
        case (r_state)
            S_CLR: begin
                map_we  = 1'b1;
                map_wa  = r_clr[IdxW-1:0];
                freq_we = 1'b1;
                freq_wa = r_clr[IdxW-1:0];
            end
            S_EVICT: begin
                if (occ_q && !r_hit) begin
                    map_we  = 1'b1;
                    map_wa  = oidx;
                    freq_we = (r_policy == POL_LFRUR);
                    freq_wa = oidx;
                end
            end
            S_COMMIT: begin
                map_we  = 1'b1;
                map_wd  = {1'b1, r_q};
                freq_we = 1'b1;
                freq_wd = f_new;
                fs_we   = 1'b1;
            end
            default: map_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) map_mem[map_wa] <= map_wd;
        map_rd <= map_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (freq_we) freq_mem[freq_wa] <= freq_wd;
        freq_rd <= freq_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) fs_mem[r_q] <= fs_wd;
        fs_rd <= fs_mem[fs_ra];
    end

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_STICKY;
            r_frames <= 7'(NumFrames);
            r_users  <= 4'(NumUsers);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[2:0];
                CFG_FRAMES: r_frames <= i_cfg_data;
                CFG_USERS:  r_users  <= i_cfg_data[3:0];
                default:    r_policy <= r_policy;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_fp    <= '0;
            r_time  <= '0;
            r_occ   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < NumUsers; i++) begin
                r_cnt[i] <= '0;
                r_pri[i] <= '0;
                r_min[i] <= '0;
                r_max[i] <= '0;
                r_pgs[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (IdxW+1)'(MapDepth - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_u   <= i_user;
                        r_pg  <= i_page;
                        r_hit <= 1'b0;
                        r_o_frame   <= '0;
                        r_o_hit     <= 1'b0;
                        r_o_evicted <= 1'b0;
                        r_o_vu      <= '0;
                        r_o_vp      <= '0;
                        r_o_status  <= ST_OK;
                        if (i_opcode == OP_LOAD) begin
                            r_pri[i_user] <= i_priority_req;
                            r_min[i_user] <= i_min_quota;
                            r_max[i_user] <= i_max_quota;
                            r_pgs[i_user] <= i_page_limit;
                            r_done        <= 1'b1;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    // map and frequency reads at the request index land next cycle
                    if ({1'b0, r_u} >= nu || {1'b0, r_pg} >= lim) begin
                        r_o_status <= ST_LIMIT;
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (map_rd[6]) begin
                        r_hit   <= 1'b1;
                        r_q     <= map_rd[FrameW-1:0];
                        r_state <= S_FRD;
                    end else if (r_cnt[r_u] < r_max[r_u] && r_fp < nf) begin
                        r_q     <= r_fp[FrameW-1:0];
                        r_fp    <= r_fp + 1'b1;
                        r_state <= S_FRD;
                    end else begin
                        for (int v = 0; v < NumUsers; v++) begin
                            if (4'(v) >= nu)
                                r_elig[v] <= 1'b0;
                            else if (3'(v) == r_u)
                                r_elig[v] <= !(r_cnt[r_u] < r_min[r_u]);
                            else
                                r_elig[v] <= (r_cnt[r_u] < r_max[r_u]) &&
                                             (r_cnt[v] > r_min[v]);
                        end
                        r_k     <= '0;
                        r_pv    <= 1'b0;
                        r_have  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN, S_TAIL: begin
                    if (upd) begin
                        r_have <= 1'b1;
                        r_best <= fs_rd.score;
                        r_bu   <= fs_rd.user;
                        r_q    <= r_kp;
                    end
                    if (r_state == S_SCAN) begin
                        r_kp <= r_k[FrameW-1:0];
                        r_pv <= 1'b1;
                        r_k  <= r_k + 1'b1;
                        if (r_k == (FrameW+1)'(NumFrames - 1)) r_state <= S_TAIL;
                    end else if (r_have || upd) begin
                        r_state <= S_FRD;
                    end else begin
                        r_o_status <= ST_NOVICT;
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_FRD: r_state <= S_EVICT;
                S_EVICT: begin
                    r_acc <= fs_rd.score;
                    if (occ_q && !r_hit) begin
                        r_o_evicted        <= 1'b1;
                        r_o_vu             <= fs_rd.user;
                        r_o_vp             <= fs_rd.page;
                        r_cnt[fs_rd.user]  <= r_cnt[fs_rd.user] - 1'b1;
                    end
                    r_state <= S_SC1;
                end
                S_SC1: begin
                    r_acc   <= alu_rsp.sum;
                    r_state <= S_SC2;
                end
                S_SC2: begin
                    r_acc   <= alu_rsp.sum;
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_occ[r_q] <= 1'b1;
                    if (!r_hit) r_cnt[r_u] <= r_cnt[r_u] + 1'b1;
                    r_time    <= r_time + 32'd1;
                    r_o_frame <= r_q;
                    r_o_hit   <= r_hit;
                    r_done    <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: test/quota_aware_page_replacement_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module quota_aware_page_replacement_tb;
    import qap_pkg::*;

    // Policy code outside the defined set; the block treats it as plain LRU.
    localparam logic [2:0] POL_SPARE = 3'd7;
    localparam int RandItems = 900;
    localparam int Phases    = 8;

    typedef struct {
        logic       op;
        logic [2:0] user;
        logic [7:0] page;
        logic [9:0] prio;
        logic [6:0] minq;
        logic [6:0] maxq;
        logic [8:0] lim;
    } t_req;

    typedef struct packed {
        logic [5:0] frame;
        logic       hit;
        logic       evicted;
        logic [2:0] vuser;
        logic [7:0] vpage;
        logic [1:0] status;
    } t_res;

    typedef struct {
        t_req r;
        bit   typed;
        t_res e;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_opcode = 1'b0;
    logic [2:0] i_user = '0;
    logic [7:0] i_page = '0;
    logic [9:0] i_priority_req = '0;
    logic [6:0] i_min_quota = '0;
    logic [6:0] i_max_quota = '0;
    logic [8:0] i_page_limit = '0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [6:0] i_cfg_data = '0;
    logic       o_done;
    logic [5:0] o_frame;
    logic       o_hit;
    logic       o_evicted;
    logic [2:0] o_victim_user;
    logic [7:0] o_victim_page;
    logic [1:0] o_status;

    quota_aware_page_replacement dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- shadow state
    logic [2:0]  pol_q;
    logic [6:0]  frames_q;
    logic [3:0]  users_q;
    logic [2:0]  own_user [NumFrames];
    logic [7:0]  own_page [NumFrames];
    bit          occupied [NumFrames];
    longint      score    [NumFrames];
    bit          resident [MapDepth];
    logic [5:0]  where    [MapDepth];
    logic [31:0] freq     [MapDepth];
    int          held     [NumUsers];
    logic [9:0]  prio_q   [NumUsers];
    int          min_q    [NumUsers];
    int          max_q    [NumUsers];
    int          pages_q  [NumUsers];
    int          free_ptr;
    logic [31:0] clock_t;

    t_res expected_results[$];
    int   errors = 0;
    int   n_hit = 0, n_evict = 0, n_novict = 0, n_limit = 0, n_load = 0, n_checked = 0;

    task automatic clear_shadow();
        pol_q = POL_STICKY;
        frames_q = 7'd64;
        users_q = 4'd8;
        for (int k = 0; k < NumFrames; k++) begin
            own_user[k] = '0;
            own_page[k] = '0;
            occupied[k] = 0;
            score[k] = 0;
        end
        for (int k = 0; k < MapDepth; k++) begin
            resident[k] = 0;
            where[k] = '0;
            freq[k] = '0;
        end
        for (int k = 0; k < NumUsers; k++) begin
            held[k] = 0;
            prio_q[k] = '0;
            min_q[k] = 0;
            max_q[k] = 0;
            pages_q[k] = 0;
        end
        free_ptr = 0;
        clock_t = '0;
    endtask

    // Work out the outcome of one request and advance the shadow state.
    function automatic t_res place_page(t_req r);
        t_res   o = '0;
        int     nf, nu, lim, idx, q, u, oidx;
        bit     was_hit, found;
        longint best, vs, kept, pri, t, f;
        int     vq;
        bit     have;
        nf = (frames_q > NumFrames) ? NumFrames : frames_q;
        nu = (users_q > NumUsers) ? NumUsers : users_q;
        u = r.user;
        if (r.op == OP_LOAD) begin
            prio_q[u] = r.prio;
            min_q[u] = r.minq;
            max_q[u] = r.maxq;
            pages_q[u] = r.lim;
            n_load++;
            return o;
        end
        lim = (pages_q[u] > NumPages) ? NumPages : pages_q[u];
        if (u >= nu || r.page >= lim) begin
            o.status = ST_LIMIT;
            n_limit++;
            return o;
        end
        idx = u * NumPages + r.page;
        was_hit = 0;
        found = 0;
        q = 0;
        kept = 0;
        if (resident[idx]) begin
            q = where[idx];
            was_hit = 1;
        end else if (held[u] < max_q[u] && free_ptr < nf) begin
            q = free_ptr;
            free_ptr++;
        end else begin
            best = 0;
            for (int v = 0; v < nu; v++) begin
                if (v == u && held[u] < min_q[u]) continue;
                if (v != u && held[u] >= max_q[u]) continue;
                if (v != u && held[v] <= min_q[v]) continue;
                have = 0;
                vs = 0;
                vq = 0;
                for (int k = 0; k < NumFrames; k++) begin
                    if (!occupied[k] || own_user[k] != v) continue;
                    if (!have || score[k] < vs) begin
                        have = 1;
                        vs = score[k];
                        vq = k;
                    end
                end
                if (have && (!found || vs < best)) begin
                    found = 1;
                    best = vs;
                    q = vq;
                end
            end
            if (!found) begin
                o.status = ST_NOVICT;
                n_novict++;
                return o;
            end
        end
        if (occupied[q]) begin
            oidx = own_user[q] * NumPages + own_page[q];
            if (was_hit) begin
                kept = score[q];
            end else begin
                o.evicted = 1'b1;
                o.vuser = own_user[q];
                o.vpage = own_page[q];
                if (pol_q == POL_LFRUR) freq[oidx] = '0;
            end
            resident[oidx] = 0;
            held[own_user[q]]--;
        end
        own_user[q] = 3'(u);
        own_page[q] = r.page;
        occupied[q] = 1;
        freq[idx] = freq[idx] + 32'd1;
        pri = 32 * longint'(prio_q[u]);
        t = clock_t;
        f = freq[idx];
        case (pol_q)
            POL_STICKY: score[q] = was_hit ? kept : t + pri;
            POL_MRU:    score[q] = -t + pri;
            POL_LFU:    score[q] = f + pri;
            POL_LFRU,
            POL_LFRUR:  score[q] = f * 64 + t + pri;
            POL_MFU:    score[q] = -f + pri;
            default:    score[q] = t + pri;
        endcase
        resident[idx] = 1;
        where[idx] = 6'(q);
        held[u]++;
        clock_t = clock_t + 32'd1;
        o.frame = 6'(q);
        o.hit = was_hit;
        if (was_hit) n_hit++;
        if (o.evicted) n_evict++;
        return o;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (o_frame !== e.frame) report("frame", o_frame, e.frame);
                if (o_hit !== e.hit) report("hit", o_hit, e.hit);
                if (o_evicted !== e.evicted) report("evicted", o_evicted, e.evicted);
                if (o_victim_user !== e.vuser) report("victim_user", o_victim_user, e.vuser);
                if (o_victim_page !== e.vpage) report("victim_page", o_victim_page, e.vpage);
                if (o_status !== e.status) report("status", o_status, e.status);
            end
        end
    end

    // ---------------------------------------------------------------- driving
    // Hold the request until the block takes it, then queue what it must return.
    task automatic issue(t_req r, bit typed, t_res want);
        t_res p;
        start <= 1'b1;
        i_opcode <= r.op;
        i_user <= r.user;
        i_page <= r.page;
        i_priority_req <= r.prio;
        i_min_quota <= r.minq;
        i_max_quota <= r.maxq;
        i_page_limit <= r.lim;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = place_page(r);
        expected_results.insert(expected_results.size(), typed ? want : p);
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_POLICY: pol_q = data[2:0];
            CFG_FRAMES: frames_q = data;
            default:    users_q = data[3:0];
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_req user_load(int u);
        t_req r;
        r.op = OP_LOAD;
        r.user = 3'(u);
        r.page = 8'($urandom);
        r.prio = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3));
        r.minq = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 3))
                                            : 7'($urandom_range(0, 64));
        case ($urandom_range(0, 4))
            0:       r.maxq = 7'd64;
            1:       r.maxq = 7'($urandom_range(0, 64));
            default: r.maxq = 7'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 5))
            0:       r.lim = 9'd256;
            1:       r.lim = 9'($urandom_range(1, 256));
            default: r.lim = 9'($urandom_range(4, 24));
        endcase
        return r;
    endfunction

    // Mostly well-formed accesses inside a small working set to force hits and
    // evictions; the rest reloads settings or strays past the page limit.
    function automatic t_req pick_request();
        t_req r;
        int   pick, nu, lim;
        pick = $urandom_range(0, 99);
        nu = (users_q > NumUsers) ? NumUsers : users_q;
        r = user_load($urandom_range(0, NumUsers - 1));
        if (pick < 10) return r;
        r.op = OP_ACCESS;
        if (pick < 16) begin
            r.user = 3'($urandom);
            r.page = 8'($urandom);
            return r;
        end
        r.user = 3'($urandom_range(0, nu - 1));
        lim = (pages_q[r.user] > NumPages) ? NumPages : pages_q[r.user];
        if (lim == 0) r.page = 8'($urandom);
        else r.page = 8'($urandom_range(0, ((lim < 24) ? lim : 24) - 1));
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus
    t_row directed[$];

    task automatic add_row(logic op, int u, int pg, int pr, int mn, int mx, int lm,
                           bit typed, t_res e);
        t_row w;
        w.r.op = op;
        w.r.user = 3'(u);
        w.r.page = 8'(pg);
        w.r.prio = 10'(pr);
        w.r.minq = 7'(mn);
        w.r.maxq = 7'(mx);
        w.r.lim = 9'(lm);
        w.typed = typed;
        w.e = e;
        directed.insert(directed.size(), w);
    endtask

    initial begin
        t_res  none, lim_res, novict_res;
        t_req  r;
        int    sent, burst, per_phase, pause_at;
        logic [2:0] pols [Phases];
        logic [6:0] frms [Phases];
        logic [3:0] usrs [Phases];

        none = '0;
        lim_res = '0;
        lim_res.status = ST_LIMIT;
        novict_res = '0;
        novict_res.status = ST_NOVICT;

        pols = '{POL_LRU, POL_MRU, POL_LFU, POL_LFRU, POL_LFRUR, POL_MFU, POL_SPARE, POL_STICKY};
        frms = '{7'd64, 7'd16, 7'd1, 7'd8, 7'd64, 7'd32, 7'd127, 7'd4};
        usrs = '{4'd8, 4'd4, 4'd1, 4'd3, 4'd8, 4'd2, 4'd15, 4'd8};

        clear_shadow();

        // Directed rows under reset settings: sticky LRU, full pool, all users.
        add_row(OP_ACCESS, 0, 0, 0, 0, 0, 0, 1, lim_res);          // no pages yet
        add_row(OP_LOAD, 0, 0, 0, 0, 2, 256, 1, none);
        add_row(OP_ACCESS, 0, 255, 0, 0, 0, 0, 0, none);           // top page, free frame
        add_row(OP_ACCESS, 0, 255, 0, 0, 0, 0, 0, none);           // hit keeps score
        add_row(OP_ACCESS, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(OP_ACCESS, 0, 1, 0, 0, 0, 0, 0, none);             // at max: self-evict
        add_row(OP_LOAD, 1, 255, 1023, 64, 64, 1, 1, none);        // field extremes
        add_row(OP_ACCESS, 1, 1, 0, 0, 0, 0, 1, lim_res);          // page at limit
        add_row(OP_ACCESS, 1, 0, 0, 0, 0, 0, 0, none);
        add_row(OP_LOAD, 2, 0, 0, 0, 0, 5, 1, none);
        add_row(OP_ACCESS, 2, 3, 0, 0, 0, 0, 1, novict_res);       // zero max, nothing held
        add_row(OP_LOAD, 7, 0, 5, 0, 64, 256, 1, none);
        add_row(OP_ACCESS, 7, 128, 0, 0, 0, 0, 0, none);
        add_row(OP_LOAD, 3, 0, 0, 0, 1, 256, 1, none);
        add_row(OP_ACCESS, 3, 7, 0, 0, 0, 0, 0, none);
        add_row(OP_ACCESS, 3, 8, 0, 0, 0, 0, 0, none);             // evicts its own page
        add_row(OP_LOAD, 0, 0, 0, 3, 0, 256, 1, none);             // max below held count
        add_row(OP_ACCESS, 0, 2, 0, 0, 0, 0, 0, none);             // no victim: self below min, max reached
        add_row(OP_ACCESS, 1, 0, 0, 0, 0, 0, 0, none);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) issue(directed[i].r, directed[i].typed, directed[i].e);
        start <= 1'b0;
        drain();

        per_phase = RandItems / Phases;
        pause_at = per_phase / 2;
        for (int ph = 0; ph < Phases; ph++) begin
            write_reg(CFG_POLICY, {4'd0, pols[ph]});
            write_reg(CFG_FRAMES, frms[ph]);
            write_reg(CFG_USERS, {3'd0, usrs[ph]});
            for (int u = 0; u < NumUsers; u++) issue(user_load(u), 0, none);
            sent = 0;
            while (sent < per_phase) begin
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 6);
                for (int b = 0; b < burst && sent < per_phase; b++) begin
                    r = pick_request();
                    issue(r, 0, none);
                    sent++;
                    // Stall the sender once per phase until the block runs dry.
                    if (sent == pause_at) begin
                        start <= 1'b0;
                        while (expected_results.size() != 0) @(posedge i_clk);
                        @(posedge i_clk);
                    end
                end
                if ($urandom_range(0, 2) != 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
                end
            end
            start <= 1'b0;
            drain();
        end

        $display("Covered %0d requests over %0d policy/pool/user settings: %0d loads,",
                 n_checked, Phases, n_load);
        $display("  %0d hits, %0d evictions, %0d without a victim, %0d beyond the limit.",
                 n_hit, n_evict, n_novict, n_limit);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (reset sweep plus every request
    // evicting and every gap at its longest).
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
